### design/plp_pkg.sv
`timescale 1ns / 1ps
// plp_pkg: shared widths, controller states, datapath commands and status
// depends on nothing

package plp_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 24;
    localparam int OIDX_W         = 6;
    localparam int TOL_W          = 23;
    localparam int TOL2_W         = 2 * TOL_W;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = 2 * DIFF_W;
    localparam int MET_W          = PROD_W + 1;
    localparam int HALF_W         = (MET_W + 1) / 2;
    localparam int ACC_W          = 4 * HALF_W;
    localparam int PT_W           = 3 * COORD_W;
    localparam int S_TDATA_W      = ((PT_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((PT_W + OIDX_W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_START, S_MARK_LAST, S_POP, S_SEG, S_RD_B, S_D_CALC,
        S_LEN_MUL, S_LEN_SUM, S_SCAN_RD, S_SCAN_E, S_SCAN_MUL, S_SCAN_CMP,
        S_MULC_GO, S_MULC_WAIT, S_MULT_GO, S_MULT_WAIT, S_JUDGE, S_KEEP,
        S_PUSH2, S_EMIT_RD, S_EMIT_CHK
    } state_t;

    typedef enum logic [4:0] {
        OP_CLEAR, OP_LOAD, OP_START, OP_MARK_LAST, OP_POP, OP_SEG, OP_RD_B,
        OP_D_CALC, OP_LEN_MUL, OP_LEN_SUM, OP_SCAN_RD, OP_SCAN_E, OP_SCAN_MUL,
        OP_SCAN_CMP, OP_MULC_GO, OP_MULC_WAIT, OP_MULT_GO, OP_MULT_WAIT,
        OP_JUDGE, OP_KEEP, OP_PUSH2, OP_EMIT_RD, OP_EMIT_CHK
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last_beat;
        logic small_run;
        logic stack_empty;
        logic seg_short;
        logic scan_last;
        logic zero_len;
        logic mul_done;
        logic keep_now;
        logic emit_adv;
        logic emit_last;
    } sts_t;

endpackage

### design/plp_ram.sv
`timescale 1ns / 1ps
// plp_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing

module plp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/plp_mul.sv
`timescale 1ns / 1ps
// plp_mul: sequential wide unsigned multiplier, four half-width partial products
// depends on plp_pkg

module plp_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [plp_pkg::MET_W-1:0] a,
    input  logic [plp_pkg::MET_W-1:0] b,
    output logic                      done,
    output logic [plp_pkg::ACC_W-1:0] prod
);
    import plp_pkg::*;

    logic [2*HALF_W-1:0] a_reg, b_reg, pp_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [2:0]          cnt_reg;
    logic [1:0]          sh_reg;
    logic                busy_reg, pv_reg;
    logic [HALF_W-1:0]   a_part, b_part;
    logic [ACC_W-1:0]    pp_ext;

    assign a_part = cnt_reg[1] ? a_reg[2*HALF_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_part = cnt_reg[0] ? b_reg[2*HALF_W-1:HALF_W] : b_reg[HALF_W-1:0];

    always_comb begin
        case (sh_reg)
            2'd0:    pp_ext = {{(2*HALF_W){1'b0}}, pp_reg};
            2'd1:    pp_ext = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_ext = {pp_reg, {(2*HALF_W){1'b0}}};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            pv_reg   <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            pv_reg   <= 1'b0;
            a_reg    <= {{(2*HALF_W-MET_W){1'b0}}, a};
            b_reg    <= {{(2*HALF_W-MET_W){1'b0}}, b};
            acc_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg < 3'd4) begin
                pp_reg <= a_part * b_part;
                sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                pv_reg <= 1'b1;
            end else begin
                pv_reg <= 1'b0;
            end
            if (pv_reg) begin
                acc_reg <= acc_reg + pp_ext;
            end
            if (cnt_reg == 3'd5) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    assign done = busy_reg && (cnt_reg == 3'd5);
    assign prod = acc_reg;

endmodule

### design/plp_datapath.sv
`timescale 1ns / 1ps
// plp_datapath: point store, keep marks, segment stack, distance math, output register
// depends on plp_pkg, plp_ram, plp_mul

module plp_datapath #(
    parameter int MAX_POINTS = plp_pkg::MAX_POINTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  plp_pkg::cmd_t                 cmd,
    output plp_pkg::sts_t                 sts,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [plp_pkg::TOL_W-1:0]     cfg_data
);
    import plp_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] count_reg, depth_reg, nm1_full, depth_m1;
    logic [IW-1:0] i_reg, lo_reg, hi_reg, best_idx_reg, nm1;
    logic          ovf_reg, pass_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [TOL2_W-1:0] tol2_reg;
    logic [COORD_W-1:0] ax_reg, az_reg;
    logic signed [DIFF_W-1:0] dx_reg, dz_reg, ex_reg, ez_reg, ex_new, ez_new;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;
    logic [MET_W-1:0] len2_reg, best_reg, sum_val, abs_val, metric;
    logic signed [MET_W-1:0] diff_val;
    logic [ACC_W-1:0] c_reg, prod;

    // stores
    logic [PT_W-1:0]   st_q;
    logic [IW-1:0]     st_raddr;
    logic              st_we, kp_we, kp_wd, kp_q, sk_we;
    logic [IW-1:0]     kp_waddr;
    logic [2*IW-1:0]   sk_wd, sk_q;
    logic [IW-1:0]     sk_lo, sk_hi;
    logic [COORD_W-1:0] st_x, st_z;

    logic beat, take, slot_free, adv;
    logic mul_start, mul_done;
    logic [MET_W-1:0] mul_a, mul_b;

    logic              mv_reg, ml_reg, mu_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [OIDX_W-1:0] oi_reg;
    logic [IW+OIDX_W-1:0] idx_w;

    assign s_tready  = (cmd.op == OP_LOAD);
    assign cfg_ready = 1'b1;
    assign beat      = s_tvalid && s_tready;

    assign nm1_full = count_reg - CW'(1);
    assign nm1      = nm1_full[IW-1:0];
    assign depth_m1 = depth_reg - CW'(1);
    assign sk_lo    = sk_q[IW-1:0];
    assign sk_hi    = sk_q[2*IW-1:IW];
    assign st_x     = st_q[COORD_W-1:0];
    assign st_z     = st_q[3*COORD_W-1:2*COORD_W];

    assign st_we = beat && (count_reg < CW'(MAX_POINTS));

    // low end lands for the anchor capture, high end for the direction;
    // the first scan read goes straight to the first interior point
    always_comb begin
        case (cmd.op)
            OP_SEG:     st_raddr = sk_lo;
            OP_RD_B:    st_raddr = lo_reg;
            OP_D_CALC:  st_raddr = hi_reg;
            OP_SCAN_RD: st_raddr = (i_reg == lo_reg) ? lo_reg + IW'(1) : i_reg;
            default:    st_raddr = i_reg;
        endcase
    end

    plp_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
        .aclk, .we(st_we), .waddr(count_reg[IW-1:0]), .wdata(s_tdata[PT_W-1:0]),
        .raddr(st_raddr), .rdata(st_q)
    );

    // emission handshake with the output register
    assign take      = pass_reg || kp_q;
    assign slot_free = !mv_reg || m_tready;
    assign adv       = !take || slot_free;

    always_comb begin
        kp_we    = 1'b0;
        kp_waddr = i_reg;
        kp_wd    = 1'b0;
        case (cmd.op)
            OP_CLEAR:     kp_we = 1'b1;
            OP_START:     begin kp_we = 1'b1; kp_waddr = '0;           kp_wd = 1'b1; end
            OP_MARK_LAST: begin kp_we = 1'b1; kp_waddr = nm1;          kp_wd = 1'b1; end
            OP_KEEP:      begin kp_we = 1'b1; kp_waddr = best_idx_reg; kp_wd = 1'b1; end
            OP_EMIT_CHK:  kp_we = adv;
            default:      kp_we = 1'b0;
        endcase
    end

    plp_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_keep (
        .aclk, .we(kp_we), .waddr(kp_waddr), .wdata(kp_wd), .raddr(i_reg), .rdata(kp_q)
    );

    always_comb begin
        sk_we = 1'b0;
        sk_wd = {hi_reg, best_idx_reg};
        case (cmd.op)
            OP_MARK_LAST: begin sk_we = 1'b1; sk_wd = {nm1, {IW{1'b0}}}; end
            OP_KEEP:      begin sk_we = 1'b1; sk_wd = {best_idx_reg, lo_reg}; end
            OP_PUSH2:     sk_we = 1'b1;
            default:      sk_we = 1'b0;
        endcase
        if (depth_reg >= CW'(MAX_POINTS)) begin
            sk_we = 1'b0;
        end
    end

    plp_ram #(.WIDTH(2*IW), .DEPTH(MAX_POINTS)) u_stack (
        .aclk, .we(sk_we), .waddr(depth_reg[IW-1:0]), .wdata(sk_wd),
        .raddr(depth_m1[IW-1:0]), .rdata(sk_q)
    );

    // distance math
    assign ex_new = $signed({st_x[COORD_W-1], st_x}) - $signed({ax_reg[COORD_W-1], ax_reg});
    assign ez_new = $signed({st_z[COORD_W-1], st_z}) - $signed({az_reg[COORD_W-1], az_reg});
    assign sum_val  = MET_W'($signed({p1_reg[PROD_W-1], p1_reg})
                    + $signed({p2_reg[PROD_W-1], p2_reg}));
    assign diff_val = $signed({p1_reg[PROD_W-1], p1_reg}) - $signed({p2_reg[PROD_W-1], p2_reg});
    assign abs_val  = diff_val[MET_W-1] ? MET_W'(-diff_val) : MET_W'(diff_val);
    assign metric   = (len2_reg == '0) ? sum_val : abs_val;

    assign mul_start = (cmd.op == OP_MULC_GO) || (cmd.op == OP_MULT_GO);
    assign mul_a = (cmd.op == OP_MULC_GO) ? best_reg : {{(MET_W-TOL2_W){1'b0}}, tol2_reg};
    assign mul_b = (cmd.op == OP_MULC_GO) ? best_reg : len2_reg;

    plp_mul u_mul (
        .aclk, .aresetn, .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done), .prod
    );

    always_ff @(posedge aclk) begin
        tol2_reg <= tol_reg * tol_reg;
        case (cmd.op)
            OP_SEG: begin
                lo_reg <= sk_lo;
                hi_reg <= sk_hi;
            end
            OP_D_CALC: begin
                ax_reg <= st_q[COORD_W-1:0];
                az_reg <= st_q[3*COORD_W-1:2*COORD_W];
            end
            OP_LEN_MUL: begin
                dx_reg <= ex_new;
                dz_reg <= ez_new;
                ex_reg <= ex_new;
                ez_reg <= ez_new;
            end
            OP_LEN_SUM: begin
                p1_reg <= ex_reg * ex_reg;
                p2_reg <= ez_reg * ez_reg;
            end
            OP_SCAN_RD: begin
                if (i_reg == lo_reg) begin
                    len2_reg <= sum_val;
                    best_reg <= '0;
                    best_idx_reg <= lo_reg;
                end
            end
            OP_SCAN_E: begin
                ex_reg <= ex_new;
                ez_reg <= ez_new;
            end
            OP_SCAN_MUL: begin
                if (len2_reg == '0) begin
                    p1_reg <= ex_reg * ex_reg;
                    p2_reg <= ez_reg * ez_reg;
                end else begin
                    p1_reg <= dx_reg * ez_reg;
                    p2_reg <= dz_reg * ex_reg;
                end
            end
            OP_SCAN_CMP: begin
                if (metric > best_reg) begin
                    best_reg     <= metric;
                    best_idx_reg <= i_reg;
                end
            end
            OP_MULC_WAIT: begin
                if (mul_done) begin
                    c_reg <= prod;
                end
            end
            default: begin
            end
        endcase
    end

    // control counters and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            depth_reg <= '0;
            i_reg     <= '0;
            ovf_reg   <= 1'b0;
            pass_reg  <= 1'b0;
            tol_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                tol_reg <= cfg_data;
            end
            if (beat) begin
                if (st_we) begin
                    count_reg <= count_reg + CW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (sk_we) begin
                depth_reg <= depth_reg + CW'(1);
            end
            case (cmd.op)
                OP_CLEAR: i_reg <= i_reg + IW'(1);
                OP_START: begin
                    i_reg     <= '0;
                    depth_reg <= '0;
                    pass_reg  <= sts.small_run;
                end
                OP_POP: begin
                    if (depth_reg == '0) begin
                        i_reg <= '0;
                    end else begin
                        depth_reg <= depth_m1;
                    end
                end
                // counter parks on the low end while len2 settles, the first
                // scan read then goes one past it
                OP_LEN_SUM: i_reg <= lo_reg;
                OP_SCAN_RD: begin
                    if (i_reg == lo_reg) begin
                        i_reg <= lo_reg + IW'(1);
                    end
                end
                OP_SCAN_CMP: begin
                    if (!sts.scan_last) begin
                        i_reg <= i_reg + IW'(1);
                    end
                end
                OP_EMIT_CHK: begin
                    if (adv) begin
                        if (sts.emit_last) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end else begin
                            i_reg <= i_reg + IW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    assign idx_w = {{OIDX_W{1'b0}}, i_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if ((cmd.op == OP_EMIT_CHK) && take && slot_free) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
        if ((cmd.op == OP_EMIT_CHK) && take && slot_free) begin
            ox_reg <= st_q[COORD_W-1:0];
            oy_reg <= st_q[2*COORD_W-1:COORD_W];
            oz_reg <= st_q[3*COORD_W-1:2*COORD_W];
            oi_reg <= idx_w[OIDX_W-1:0];
            ml_reg <= sts.emit_last;
            mu_reg <= ovf_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(M_TDATA_W-PT_W-OIDX_W){1'b0}}, oi_reg, oz_reg, oy_reg, ox_reg};
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    // status
    always_comb begin
        sts.clear_done  = (i_reg == IW'(MAX_POINTS - 1));
        sts.last_beat   = beat && s_tlast;
        sts.small_run   = (count_reg < CW'(3)) || (tol_reg == '0);
        sts.stack_empty = (depth_reg == '0);
        sts.seg_short   = ({1'b0, sk_hi} <= ({1'b0, sk_lo} + (IW+1)'(1)));
        sts.scan_last   = (({1'b0, i_reg} + (IW+1)'(1)) == {1'b0, hi_reg});
        sts.zero_len    = (len2_reg == '0);
        sts.mul_done    = mul_done;
        sts.keep_now    = (len2_reg == '0) ? (best_reg > {{(MET_W-TOL2_W){1'b0}}, tol2_reg})
                                           : (c_reg > prod);
        sts.emit_adv    = adv;
        sts.emit_last   = (i_reg == nm1);
    end

endmodule

### design/plp_ctrl.sv
`timescale 1ns / 1ps
// plp_ctrl: sequencer for load, segment stack walk, keep decision and emission
// depends on plp_pkg

module plp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  plp_pkg::sts_t sts,
    output plp_pkg::cmd_t cmd
);
    import plp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:      if (sts.last_beat) state_next = S_START;
            S_START:     state_next = sts.small_run ? S_EMIT_RD : S_MARK_LAST;
            S_MARK_LAST: state_next = S_POP;
            S_POP:       state_next = sts.stack_empty ? S_EMIT_RD : S_SEG;
            S_SEG:       state_next = sts.seg_short ? S_POP : S_RD_B;
            S_RD_B:      state_next = S_D_CALC;
            S_D_CALC:    state_next = S_LEN_MUL;
            S_LEN_MUL:   state_next = S_LEN_SUM;
            S_LEN_SUM:   state_next = S_SCAN_RD;
            S_SCAN_RD:   state_next = S_SCAN_E;
            S_SCAN_E:    state_next = S_SCAN_MUL;
            S_SCAN_MUL:  state_next = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (!sts.scan_last) begin
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = sts.zero_len ? S_JUDGE : S_MULC_GO;
                end
            end
            S_MULC_GO:   state_next = S_MULC_WAIT;
            S_MULC_WAIT: if (sts.mul_done) state_next = S_MULT_GO;
            S_MULT_GO:   state_next = S_MULT_WAIT;
            S_MULT_WAIT: if (sts.mul_done) state_next = S_JUDGE;
            S_JUDGE:     state_next = sts.keep_now ? S_KEEP : S_POP;
            S_KEEP:      state_next = S_PUSH2;
            S_PUSH2:     state_next = S_POP;
            S_EMIT_RD:   state_next = S_EMIT_CHK;
            S_EMIT_CHK: begin
                if (sts.emit_adv) begin
                    state_next = sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:     state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_CLEAR:     cmd.op = OP_CLEAR;
            S_IDLE:      cmd.op = OP_LOAD;
            S_START:     cmd.op = OP_START;
            S_MARK_LAST: cmd.op = OP_MARK_LAST;
            S_POP:       cmd.op = OP_POP;
            S_SEG:       cmd.op = OP_SEG;
            S_RD_B:      cmd.op = OP_RD_B;
            S_D_CALC:    cmd.op = OP_D_CALC;
            S_LEN_MUL:   cmd.op = OP_LEN_MUL;
            S_LEN_SUM:   cmd.op = OP_LEN_SUM;
            S_SCAN_RD:   cmd.op = OP_SCAN_RD;
            S_SCAN_E:    cmd.op = OP_SCAN_E;
            S_SCAN_MUL:  cmd.op = OP_SCAN_MUL;
            S_SCAN_CMP:  cmd.op = OP_SCAN_CMP;
            S_MULC_GO:   cmd.op = OP_MULC_GO;
            S_MULC_WAIT: cmd.op = OP_MULC_WAIT;
            S_MULT_GO:   cmd.op = OP_MULT_GO;
            S_MULT_WAIT: cmd.op = OP_MULT_WAIT;
            S_JUDGE:     cmd.op = OP_JUDGE;
            S_KEEP:      cmd.op = OP_KEEP;
            S_PUSH2:     cmd.op = OP_PUSH2;
            S_EMIT_RD:   cmd.op = OP_EMIT_RD;
            S_EMIT_CHK:  cmd.op = OP_EMIT_CHK;
            default:     cmd.op = OP_CLEAR;
        endcase
    end

endmodule

### design/polyline_simplifier.sv
`timescale 1ns / 1ps
// polyline_simplifier: douglas-peucker simplification in the xz plane, top level
// load: one beat per cycle while idle; last beat -> start, mark last, the segment walk, a final pop
// per segment: pop and check with no interior point, else anchor, direction, length, a scan
// per interior point, the two wide multiplies at nonzero length, a double push on a keep
// emission reads each stored point, can stall; reset: keep marks swept clear, s_tready low

module polyline_simplifier #(
    parameter int MAX_POINTS = plp_pkg::MAX_POINTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // point beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plp_pkg::S_TDATA_W-1:0] s_tdata,  // point_x, point_y, point_z
    input  logic                          s_tlast,  // last_point
    // kept point beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plp_pkg::M_TDATA_W-1:0] m_tdata,  // out_x, out_y, out_z, out_index, pad
    output logic                          m_tlast,  // end_of_run
    output logic                          m_tuser,  // overflowed
    // tolerance register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [plp_pkg::TOL_W-1:0]     cfg_data
);
    import plp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: walks the segment stack, issues one command per cycle
    plp_ctrl u_ctrl (
        .aclk, .aresetn, .sts, .cmd
    );

    // storage, arithmetic and the output register
    plp_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_data
    );

endmodule

### design/plp_checker.sv
`timescale 1ns / 1ps
// plp_checker: port-level checks on the simplifier's beats over time
// depends on plp_pkg; bound to polyline_simplifier

module plp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [plp_pkg::M_TDATA_W-1:0] m_tdata
);

    // no result beat right after reset
    a_no_out_after_reset: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // clearing sweep keeps the input closed after reset
    a_no_in_after_reset: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !s_tready)
        else $error("s_tready high during clearing sweep");

    // a last beat starts the run, no further point taken next cycle
    a_run_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after last point");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind polyline_simplifier plp_checker u_plp_checker (.*);
